>>> rtl/wosc_pkg.sv
// Package for the waveform oscillator: sizes, types, waveform codes and
// the elaboration-time generator for the quarter-wave sine table.
// Depends on nothing; every other file uses it.
`default_nettype none

package wosc_pkg;

  // Sizing
  localparam int TABLE_ADDR_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int STEP_BITS       = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int ROM_AW          = TABLE_ADDR_BITS + 1;
  localparam int ROM_DW          = SAMPLE_BITS - 1;
  localparam int ROM_DEPTH       = (1 << TABLE_ADDR_BITS) + 1;
  localparam int QUARTER_LEN     = 1 << TABLE_ADDR_BITS;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [STEP_BITS-1:0]          step_t;
  typedef logic [ROM_AW-1:0]             rom_addr_t;
  typedef logic [ROM_DW-1:0]             rom_data_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef rom_data_t                     rom_arr_t [ROM_DEPTH];

  // Full-scale sample values
  localparam sample_t SAMPLE_MAX  = sample_t'(16'sh7FFF);
  localparam sample_t SAMPLE_MIN  = sample_t'(16'sh8000);
  localparam sample_t SAMPLE_ZERO = sample_t'(16'sh0000);

  // Waveform register codes
  typedef enum logic [1:0] {
    WF_SINE     = 2'd0,
    WF_RAMP     = 2'd1,
    WF_PULSE    = 2'd2,
    WF_SILENT   = 2'd3
  } wave_e;

  // Item held between the phase stage and the output stage
  typedef struct packed {
    logic                   valid;
    logic                   present;
    wave_e                  wave;
    logic                   neg;   // sine sign: second half cycle
    logic [SAMPLE_BITS-1:0] top;   // top phase bits for saw and square
  } s1_t;

  // Q30 fixed-point helpers, only used at elaboration
  localparam longint Q30_ONE = 64'sd1073741824;

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) / Q30_ONE;
  endfunction

  // Quarter-wave sine, odd degree-9 polynomial in Q30, rounded to Q1.15
  function automatic rom_arr_t sine_rom_init();
    rom_arr_t tbl;
    longint   x;
    longint   x2;
    longint   r;
    longint   s;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x  = longint'(i) * (Q30_ONE >>> TABLE_ADDR_BITS);
      x2 = q30_mul(x, x);
      r  = 64'sd172272;
      r  = q30_mul(r, x2) - 64'sd5026995;
      r  = q30_mul(r, x2) + 64'sd85569306;
      r  = q30_mul(r, x2) - 64'sd693598669;
      r  = q30_mul(r, x2) + 64'sd1686629713;
      s  = q30_mul(r, x);
      if (s < 0) begin
        s = 0;
      end
      s = (s + 64'sd16384) / 64'sd32768;
      if (s > 64'sd32767) begin
        s = 64'sd32767;
      end
      tbl[i] = rom_data_t'(s);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wosc_if.sv
// Handshake channels of the waveform oscillator: tick input, sample
// output and waveform register write. Depends on wosc_pkg.
`default_nettype none

interface wosc_in_if;
  logic                  valid;
  logic                  ready;
  logic                  present;
  wosc_pkg::step_t       phase_step;

  modport source (output valid, present, phase_step, input ready);
  modport sink   (input valid, present, phase_step, output ready);
endinterface

interface wosc_out_if;
  logic                  valid;
  logic                  ready;
  wosc_pkg::sample_t     sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface wosc_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            waveform;

  modport source (output valid, waveform, input ready);
  modport sink   (input valid, waveform, output ready);
endinterface

`default_nettype wire

>>> rtl/wosc_rom.sv
// Quarter-wave sine ROM with registered read, contents built at
// elaboration by wosc_pkg::sine_rom_init. Depends on wosc_pkg.
`default_nettype none

module wosc_rom (
  input  logic                clk_i,
  input  logic                en_i,
  input  wosc_pkg::rom_addr_t addr_i,
  output wosc_pkg::rom_data_t data_o
);
  import wosc_pkg::*;

  localparam rom_arr_t Rom = sine_rom_init();

  rom_data_t data_q;

  // Registered read, holds while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= Rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/wosc_phase.sv
// Phase accumulator and first pipeline stage: captures each tick, forms
// the sine table address and advances or clears the phase.
// Depends on wosc_pkg.
`default_nettype none

module wosc_phase (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                adv_i,
  input  logic                present_i,
  input  wosc_pkg::step_t     phase_step_i,
  input  wosc_pkg::wave_e     wave_i,
  output wosc_pkg::rom_addr_t rom_addr_o,
  output wosc_pkg::s1_t       s1_o
);
  import wosc_pkg::*;

  localparam int IdxLsb = PHASE_BITS - TABLE_ADDR_BITS - 2;

  phase_t                   phase_q, phase_d;
  phase_t                   step_al;
  logic [1:0]               quad;
  logic [TABLE_ADDR_BITS-1:0] frac;

  logic                     s1_valid_q;
  logic                     s1_present_q;
  wave_e                    s1_wave_q;
  logic                     s1_neg_q;
  logic [SAMPLE_BITS-1:0]   s1_top_q;

  // Line the 0.32 step up with the accumulator
  if (PHASE_BITS >= STEP_BITS) begin : g_step_wide
    assign step_al = phase_t'(phase_step_i) << (PHASE_BITS - STEP_BITS);
  end else begin : g_step_narrow
    assign step_al = phase_t'(phase_step_i >> (STEP_BITS - PHASE_BITS));
  end

  // Sine table address: quadrant picks direct or mirrored index
  assign quad = phase_q[PHASE_BITS-1 -: 2];
  assign frac = phase_q[IdxLsb +: TABLE_ADDR_BITS];

  always_comb begin
    if (quad[0]) begin
      rom_addr_o = rom_addr_t'(QUARTER_LEN) - {1'b0, frac};
    end else begin
      rom_addr_o = {1'b0, frac};
    end
  end

  // Next phase: advance on a present tick, clear on an absent one, hold with no tick
  always_comb begin
    phase_d = phase_q;
    if (load_i) begin
      if (present_i) begin
        phase_d = phase_q + step_al;
      end else begin
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage payload, taken with the item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_present_q <= present_i;
      s1_wave_q    <= wave_i;
      s1_neg_q     <= quad[1];
      s1_top_q     <= phase_q[PHASE_BITS-1 -: SAMPLE_BITS];
    end
  end

  assign s1_o = '{valid:   s1_valid_q,
                  present: s1_present_q,
                  wave:    s1_wave_q,
                  neg:     s1_neg_q,
                  top:     s1_top_q};

  // A tick without a frequency leaves the phase at zero
  a_clear_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && !present_i |=> phase_q == '0)
    else $error("phase not cleared after an item without present");

  // A present tick advances the phase by exactly the aligned step
  a_advance_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && present_i |=> phase_q == $past(phase_q + step_al))
    else $error("phase did not advance by the step");

  // A stalled stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !load_i && !adv_i |=> s1_valid_q)
    else $error("stage item dropped while stalled");

endmodule

`default_nettype wire

>>> rtl/waveform_oscillator.sv
// Top level of the waveform oscillator: handshakes, waveform register,
// sample select and output register. Depends on wosc_pkg, wosc_if,
// wosc_rom and wosc_phase.
`default_nettype none

// Direct digital synthesis oscillator. Each accepted item is one sample
// tick and gives exactly one Q1.15 sample, in order. A new item is
// accepted every clock cycle while the output side keeps up. Accepting
// an item loads the stage register and the sine ROM's registered read
// together, and the output register is loaded from them when the
// pipeline advances. With the output stalled the block holds two items and then
// holds off its input. The phase is taken for the sample before the step
// is added; a tick with present low gives zero and restarts the phase at
// zero. The waveform register (0 sine, 1 sawtooth, 2 square, 3 silent)
// may be written only while no item is in flight; it is always ready.
// The sine table is a constant ROM and needs no initialisation after
// reset.
module waveform_oscillator (
  input  logic clk_i,
  input  logic rst_ni,
  wosc_in_if.sink    in_i,
  wosc_out_if.source out_o,
  wosc_cfg_if.sink   cfg_i
);
  import wosc_pkg::*;

  wave_e     wave_q;
  logic      in_acc;
  logic      adv;
  rom_addr_t rom_addr;
  rom_data_t rom_data;
  s1_t       s1;
  sample_t   sample_d, sample_q;
  sample_t   sine_mag;
  logic      out_valid_q;

  // Waveform register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WF_SINE;
    end else if (cfg_i.valid) begin
      wave_q <= wave_e'(cfg_i.waveform);
    end
  end

  // Pipeline moves when the output register is free or being emptied
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1.valid || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  wosc_phase u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc),
    .adv_i        (adv),
    .present_i    (in_i.present),
    .phase_step_i (in_i.phase_step),
    .wave_i       (wave_q),
    .rom_addr_o   (rom_addr),
    .s1_o         (s1)
  );

  wosc_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Sample select
  assign sine_mag = sample_t'({1'b0, rom_data});

  always_comb begin
    sample_d = SAMPLE_ZERO;
    if (s1.present) begin
      case (s1.wave)
        WF_SINE:  sample_d = s1.neg ? -sine_mag : sine_mag;
        WF_RAMP:  sample_d = sample_t'({~s1.top[SAMPLE_BITS-1],
                                        s1.top[SAMPLE_BITS-2:0]});
        WF_PULSE: sample_d = s1.top[SAMPLE_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
        default:  sample_d = SAMPLE_ZERO;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1.valid) begin
      sample_q <= sample_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  // Absent ticks and the silent waveform give a zero sample
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1.valid && (!s1.present || s1.wave == WF_SILENT)
    |=> out_valid_q && sample_q == SAMPLE_ZERO)
    else $error("expected a zero sample");

  // Square output sits only at full scale
  a_square_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1.valid && s1.present && s1.wave == WF_PULSE
    |=> sample_q == SAMPLE_MAX || sample_q == SAMPLE_MIN)
    else $error("square sample not at full scale");

  // A waiting result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(sample_q))
    else $error("output item changed while stalled");

endmodule

`default_nettype wire

>>> test/wosc_checker.sv
// Scoreboard for the waveform oscillator: watches the tick, sample and
// waveform channels, predicts each sample and compares it in order.
// Depends on wosc_pkg and the channel interfaces in wosc_if.
`timescale 1ns / 100ps

module wosc_checker
  import wosc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  wosc_in_if   tick_mon,
  wosc_out_if  samp_mon,
  wosc_cfg_if  wave_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   compared_o
);

  localparam int     IDX_SHIFT = PHASE_BITS - TABLE_ADDR_BITS - 2;
  localparam longint FIX_ONE   = 64'sd1 << 30;

  // Predictor state: phase accumulator and selected waveform
  phase_t  phase_q;
  wave_e   wave_q;
  sample_t want_samples[$];

  // Quarter-wave magnitudes, index 0 .. QUARTER_LEN inclusive
  logic [ROM_DW-1:0] quarter_mag [QUARTER_LEN+1];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    compared_o   = 0;
  end

  // Q30 product, truncated toward zero
  function automatic longint fix_mul(longint a, longint b);
    return (a * b) / FIX_ONE;
  endfunction

  // sin(pi/2 * idx / QUARTER_LEN) via odd degree-9 polynomial, to Q1.15
  function automatic logic [ROM_DW-1:0] quarter_entry(int idx);
    longint coef [4];
    longint ang;
    longint ang2;
    longint acc;
    longint amp;
    coef = '{-64'sd5026995, 64'sd85569306, -64'sd693598669, 64'sd1686629713};
    ang  = longint'(idx) * (FIX_ONE / QUARTER_LEN);
    ang2 = fix_mul(ang, ang);
    acc  = 64'sd172272;
    foreach (coef[k]) acc = fix_mul(acc, ang2) + coef[k];
    amp = fix_mul(acc, ang);
    if (amp < 0) amp = 0;
    amp = (amp + 64'sd16384) / 64'sd32768;
    if (amp > 64'sd32767) amp = 64'sd32767;
    return amp[ROM_DW-1:0];
  endfunction

  initial begin
    for (int i = 0; i <= QUARTER_LEN; i++) quarter_mag[i] = quarter_entry(i);
  end

  // Sample for a given phase, before the step is added
  function automatic sample_t wave_sample(phase_t ph, wave_e w);
    logic [1:0]             quad;
    int                     addr;
    logic [SAMPLE_BITS-1:0] top;
    sample_t                mag;
    quad = ph[PHASE_BITS-1 -: 2];
    top  = ph[PHASE_BITS-1 -: SAMPLE_BITS];
    case (w)
      WF_SINE: begin
        addr = int'(ph[IDX_SHIFT +: TABLE_ADDR_BITS]);
        // odd quadrants read the table mirrored
        if (quad[0]) addr = QUARTER_LEN - addr;
        mag = sample_t'({1'b0, quarter_mag[addr]});
        return quad[1] ? -mag : mag;
      end
      WF_RAMP:  return sample_t'({~top[SAMPLE_BITS-1], top[SAMPLE_BITS-2:0]});
      WF_PULSE: return ph[PHASE_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
      default:  return SAMPLE_ZERO;
    endcase
  endfunction

  // Step widened or narrowed to the accumulator width
  function automatic phase_t step_to_phase(step_t stp);
    if (PHASE_BITS >= STEP_BITS) return phase_t'(stp) << (PHASE_BITS - STEP_BITS);
    return phase_t'(stp >> (STEP_BITS - PHASE_BITS));
  endfunction

  // Compare outgoing samples, then track register writes and new ticks
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      phase_q = '0;
      wave_q  = WF_SINE;
      want_samples.delete();
      pending_o = 0;
    end else begin
      if (samp_mon.valid && samp_mon.ready) begin
        if (want_samples.size() == 0) begin
          $error("sample: no item expected, got %0d", samp_mon.sample);
          fail_count_o++;
        end else begin
          want = want_samples.pop_front();
          if (samp_mon.sample !== want) begin
            $error("sample: expected %0d, got %0d", want, samp_mon.sample);
            fail_count_o++;
          end
          compared_o++;
        end
      end
      if (wave_mon.valid && wave_mon.ready) wave_q = wave_e'(wave_mon.waveform);
      if (tick_mon.valid && tick_mon.ready) begin
        if (tick_mon.present) begin
          want_samples.push_back(wave_sample(phase_q, wave_q));
          phase_q = phase_q + step_to_phase(tick_mon.phase_step);
        end else begin
          // absent tick: silence and restart the phase
          want_samples.push_back(SAMPLE_ZERO);
          phase_q = '0;
        end
      end
      pending_o = want_samples.size();
    end
  end

endmodule

>>> test/tb_waveform_oscillator.sv
// Testbench top for the waveform oscillator: clock, reset, tick and
// register stimulus, output back-pressure and the verdict.
// Depends on wosc_pkg, wosc_if, the oscillator RTL and wosc_checker.
`timescale 1ns / 100ps

module tb_waveform_oscillator;
  import wosc_pkg::*;

  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;

  logic clk;
  logic rst_n;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int ticks_sent;
  int wave_writes;
  int stall_cycles;
  int fail_count;
  int pending;
  int compared;

  wosc_in_if  tick_if ();
  wosc_out_if samp_if ();
  wosc_cfg_if wave_if ();

  waveform_oscillator uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .out_o  (samp_if),
    .cfg_i  (wave_if)
  );

  wosc_checker scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .tick_mon     (tick_if),
    .samp_mon     (samp_if),
    .wave_mon     (wave_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  // Clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: too long without any item moving ends the run
  always @(posedge clk) begin
    if ((tick_if.valid && tick_if.ready) || (samp_if.valid && samp_if.ready) ||
        (wave_if.valid && wave_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("waveform_oscillator verification failed");
      $finish;
    end
  end

  // Sample receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        samp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        samp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        samp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one tick, with an occasional gap before it
  task automatic push_tick(input logic pres, input step_t stp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tick_if.valid      <= 1'b1;
    tick_if.present    <= pres;
    tick_if.phase_step <= stp;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drain all samples, then write the waveform register
  task automatic write_wave(input wave_e w);
    tick_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    wave_if.valid    <= 1'b1;
    wave_if.waveform <= w;
    @(posedge clk);
    while (!wave_if.ready) @(posedge clk);
    wave_if.valid <= 1'b0;
    wave_writes++;
  endtask

  // Mostly random steps, with fine, near-full-cycle and quarter-ish ones
  function automatic step_t pick_step();
    case ($urandom_range(0, 5))
      0:       return step_t'($urandom_range(0, 32'h000F_FFFF));
      1:       return ~step_t'($urandom_range(0, 32'h000F_FFFF));
      2:       return {2'($urandom_range(0, 3)), 30'h0} ^ step_t'($urandom_range(0, 1023));
      default: return step_t'($urandom());
    endcase
  endfunction

  initial begin
    wave_e order [4];
    wave_e w;
    order = '{WF_PULSE, WF_SINE, WF_SILENT, WF_RAMP};

    rst_n              = 1'b0;
    tick_if.valid      = 1'b0;
    tick_if.present    = 1'b0;
    tick_if.phase_step = '0;
    samp_if.ready      = 1'b0;
    wave_if.valid      = 1'b0;
    wave_if.waveform   = WF_SINE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sine at the reset setting: quadrant points, wrap, absent tick
    push_tick(1'b1, 32'h0000_0000);
    repeat (4) push_tick(1'b1, 32'h4000_0000);
    push_tick(1'b1, 32'hFFFF_FFFF);
    push_tick(1'b1, 32'h0010_0000);
    push_tick(1'b0, 32'hFFFF_FFFF);
    push_tick(1'b1, 32'h8000_0001);
    push_tick(1'b1, 32'h0000_0000);

    // Sawtooth: both extremes and the wrap
    write_wave(WF_RAMP);
    push_tick(1'b1, 32'h8000_0000);
    push_tick(1'b1, 32'h8000_0000);
    push_tick(1'b1, 32'hFFFF_FFFF);
    push_tick(1'b1, 32'h0000_0001);
    push_tick(1'b0, 32'h0000_0000);

    // Square: just either side of half a cycle
    write_wave(WF_PULSE);
    push_tick(1'b1, 32'h7FFF_FFFF);
    push_tick(1'b1, 32'h0000_0001);
    push_tick(1'b1, 32'h8000_0000);
    push_tick(1'b0, 32'h1234_5678);

    // Silent: zero out while the phase keeps moving
    write_wave(WF_SILENT);
    push_tick(1'b1, 32'hFFFF_FFFF);
    push_tick(1'b1, 32'h5555_5555);
    push_tick(1'b0, 32'h0000_0000);

    // Random phases, each at one waveform setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      w = (ph < 4) ? order[ph] : wave_e'($urandom_range(0, 3));
      write_wave(w);
      idle_on = (ph < NUM_PHASES - 1);
      // hold the output back so the pipeline fills and stalls the input
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_tick(1'($urandom_range(0, 24) != 0), pick_step());
      end
    end

    // Drain and let any stray sample show up
    tick_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);

    $display("Run covered %0d ticks over %0d waveform writes, %0d samples compared.",
             ticks_sent, wave_writes, compared);
    $display("Included a %0d-cycle output hold-off and a final stretch with no idling.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("waveform_oscillator verification clean");
    end else begin
      $display("waveform_oscillator verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wosc_pkg.sv
rtl/wosc_if.sv
rtl/wosc_rom.sv
rtl/wosc_phase.sv
rtl/waveform_oscillator.sv
test/wosc_checker.sv
test/tb_waveform_oscillator.sv
